[rtl/sgme_pkg.sv]
// ----------------------------------------------------------------------------
// sgme_pkg - shared types and constants of the stereo gain/mix/echo block
// Holds the sequencer states, register indexes and Q1.23 reset values.
// ----------------------------------------------------------------------------
package sgme_pkg;

	// Register index port width and register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADROOM_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AFTER_DELAY_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_AMOUNT    = 3'd4;

	// Echo distance is always a 4-bit count
	localparam int DELAY_W = 4;

	// Reset values in Q1.23 (24-bit samples, 23-bit threshold)
	localparam int     REF_SAMPLE_BITS      = 24;
	localparam longint INPUT_GAIN_RST       = 64'sd4204440;
	localparam longint HEADROOM_GAIN_RST    = 64'sd5938679;
	localparam longint AFTER_DELAY_GAIN_RST = 64'sd6663556;
	localparam longint LIMIT_THRESHOLD_RST  = 64'sd8380219;
	localparam logic [DELAY_W-1:0] DELAY_AMOUNT_RST = 4'd4;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL_L,
		ST_MUL_R,
		ST_LIM_R,
		ST_SUM,
		ST_LEFT,
		ST_OUT
	} sgme_state_t;

endpackage

[rtl/sgme_mul_lim.sv]
// ----------------------------------------------------------------------------
// sgme_mul_lim - shared fractional multiplier with limiter
// Registers the full signed product, then scales it down by the fraction
// bits (rounding toward minus infinity) and clips it to +/- threshold.
// ----------------------------------------------------------------------------
module sgme_mul_lim import sgme_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [SAMPLE_BITS-1:0] a,
	input  logic signed [SAMPLE_BITS-1:0] b,
	input  logic        [SAMPLE_BITS-2:0] thr,
	output logic signed [SAMPLE_BITS-1:0] lim
);

	localparam int PW = 2 * SAMPLE_BITS;

	logic signed [PW-1:0]          prod_q;
	logic signed [SAMPLE_BITS:0]   scaled;
	logic signed [SAMPLE_BITS:0]   pos_thr;
	logic signed [SAMPLE_BITS:0]   neg_thr;

	// Capture the product of the selected operands
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	// Drop the fraction bits: arithmetic shift keeps the floor
	assign scaled  = prod_q[PW-1:SAMPLE_BITS-1];
	assign pos_thr = signed'({2'b00, thr});
	assign neg_thr = -pos_thr;

	// Clip to the threshold magnitude
	always_comb begin
		if (scaled > pos_thr) begin
			lim = pos_thr[SAMPLE_BITS-1:0];
		end else if (scaled < neg_thr) begin
			lim = neg_thr[SAMPLE_BITS-1:0];
		end else begin
			lim = scaled[SAMPLE_BITS-1:0];
		end
	end

endmodule

[rtl/sgme_ring.sv]
// ----------------------------------------------------------------------------
// sgme_ring - echo history memory for both channels
// One write port and one registered read port; each word holds the
// right sample above the left sample.
// ----------------------------------------------------------------------------
module sgme_ring import sgme_pkg::*; #(
	parameter int RING_DEPTH  = 16,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(RING_DEPTH)-1:0] waddr,
	input  logic [2*SAMPLE_BITS-1:0]      wdata,
	input  logic                          re,
	input  logic [$clog2(RING_DEPTH)-1:0] raddr,
	output logic [2*SAMPLE_BITS-1:0]      rdata
);

	logic [2*SAMPLE_BITS-1:0] mem_q [RING_DEPTH];
	logic [2*SAMPLE_BITS-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/stereo_gain_mix_echo.sv]
// Sequence: ST_MUL_L, ST_MUL_R, ST_LIM_R, ST_SUM, ST_LEFT, then ST_OUT until the
//   output is free; one pair at a time, and the single shared multiplier is
//   used four times per pair (left gain, right gain, centre, after-delay gain).
// Reset (arst_n low, asynchronous): configuration and control registers return to
//   their defaults, then a clearing pass zeroes the echo memory; s_axis_tready
//   stays low during it while configuration writes are taken.
// ----------------------------------------------------------------------------
// stereo_gain_mix_echo - stereo gain, centre mix and feed-forward echo
// Sequencer around one multiply/limit unit and a shared two-channel ring.
// ----------------------------------------------------------------------------
module stereo_gain_mix_echo import sgme_pkg::*; #(
	parameter int RING_DEPTH  = 16,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [SAMPLE_BITS-1:0] cfg_data,
	// Input stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata, // left_in, right_in
	// Output stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [((3*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata  // left_out, right_out, center_out
);

	localparam int SB    = SAMPLE_BITS;
	localparam int AW    = $clog2(RING_DEPTH);
	localparam int OUT_W = ((3*SB+7)/8)*8;
	localparam int SH_UP = (SB > REF_SAMPLE_BITS) ? SB - REF_SAMPLE_BITS : 0;
	localparam int SH_DN = (SB < REF_SAMPLE_BITS) ? REF_SAMPLE_BITS - SB : 0;

	localparam logic signed [SB-1:0] IG_RST  = SB'((INPUT_GAIN_RST <<< SH_UP) >>> SH_DN);
	localparam logic signed [SB-1:0] HG_RST  = SB'((HEADROOM_GAIN_RST <<< SH_UP) >>> SH_DN);
	localparam logic signed [SB-1:0] ADG_RST = SB'((AFTER_DELAY_GAIN_RST <<< SH_UP) >>> SH_DN);
	localparam logic [SB-2:0] THR_RST = (SB-1)'((LIMIT_THRESHOLD_RST <<< SH_UP) >>> SH_DN);

	localparam logic [AW-1:0] DEPTH_A   = AW'(RING_DEPTH);
	localparam logic [AW-1:0] LAST_A    = AW'(RING_DEPTH - 1);
	localparam logic [DELAY_W:0] DEPTH_CLIP =
		(RING_DEPTH > 16) ? 5'd16 : (DELAY_W+1)'(RING_DEPTH);

	localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

	// Configuration registers
	logic signed [SB-1:0] input_gain_q;
	logic signed [SB-1:0] headroom_gain_q;
	logic signed [SB-1:0] after_delay_gain_q;
	logic        [SB-2:0] limit_threshold_q;
	logic [DELAY_W-1:0]   delay_amount_q;

	// Sequencer and datapath registers
	sgme_state_t          state_q, state_d;
	logic [AW-1:0]        wp_q;
	logic [AW-1:0]        clr_q;
	logic signed [SB-1:0] in_l_q, in_r_q;
	logic signed [SB-1:0] lg_q, rg_q, le_q, re_q, center_q;
	logic signed [SB-1:0] left_out_q, right_out_q, center_out_q;
	logic                 out_valid_q;

	// Control decoded from the state
	logic                 in_take;
	logic                 out_free;
	logic                 out_load;
	logic                 mul_en;
	logic signed [SB-1:0] mul_a, mul_b;
	logic signed [SB-1:0] lim_res;
	logic                 ring_we, ring_re;
	logic [AW-1:0]        ring_waddr;
	logic [2*SB-1:0]      ring_wdata, ring_rdata;
	logic [DELAY_W-1:0]   dmod;
	logic [AW-1:0]        dmod_a;
	logic [AW-1:0]        rp;
	logic signed [SB-1:0] echo_l, echo_r;

	// Add two samples, saturating to full scale
	function automatic logic signed [SB-1:0] sat_add(input logic signed [SB-1:0] x,
	                                                input logic signed [SB-1:0] y);
		logic signed [SB:0] s;
		s = {x[SB-1], x} + {y[SB-1], y};
		if (s[SB] != s[SB-1]) begin
			return s[SB] ? SAMPLE_MIN : SAMPLE_MAX;
		end
		return s[SB-1:0];
	endfunction

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_gain_q       <= IG_RST;
			headroom_gain_q    <= HG_RST;
			after_delay_gain_q <= ADG_RST;
			limit_threshold_q  <= THR_RST;
			delay_amount_q     <= DELAY_AMOUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INPUT_GAIN:       input_gain_q       <= cfg_data;
				CFG_HEADROOM_GAIN:    headroom_gain_q    <= cfg_data;
				CFG_AFTER_DELAY_GAIN: after_delay_gain_q <= cfg_data;
				CFG_LIMIT_THRESHOLD:  limit_threshold_q  <= cfg_data[SB-2:0];
				CFG_DELAY_AMOUNT:     delay_amount_q     <= cfg_data[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_take  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and unit control
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		mul_en        = 1'b0;
		mul_a         = in_l_q;
		mul_b         = input_gain_q;
		ring_we       = 1'b0;
		ring_re       = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ring_we = 1'b1;
				if (clr_q == LAST_A) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_MUL_L;
				end
			end
			ST_MUL_L: begin
				mul_en  = 1'b1;
				ring_re = 1'b1;
				state_d = ST_MUL_R;
			end
			ST_MUL_R: begin
				mul_en  = 1'b1;
				mul_a   = in_r_q;
				state_d = ST_LIM_R;
			end
			ST_LIM_R: begin
				state_d = ST_SUM;
			end
			ST_SUM: begin
				mul_en  = 1'b1;
				mul_a   = sat_add(lg_q, rg_q);
				mul_b   = headroom_gain_q;
				ring_we = 1'b1;
				state_d = ST_LEFT;
			end
			ST_LEFT: begin
				mul_en  = 1'b1;
				mul_a   = le_q;
				mul_b   = after_delay_gain_q;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Advance the write position once per delivered pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= LAST_A;
		end else if (out_load) begin
			wp_q <= (wp_q == LAST_A) ? '0 : wp_q + 1'b1;
		end
	end

	// Fold the echo distance into the ring depth
	always_comb begin
		dmod = delay_amount_q;
		for (int i = 0; i < 8; i++) begin
			if ({1'b0, dmod} >= DEPTH_CLIP) begin
				dmod = dmod - DEPTH_CLIP[DELAY_W-1:0];
			end
		end
	end

	assign dmod_a = AW'(dmod);
	assign rp     = wp_q - dmod_a + ((wp_q < dmod_a) ? DEPTH_A : '0);

	// Shared multiply and limit unit
	sgme_mul_lim #(
		.SAMPLE_BITS(SB)
	) u_mul_lim (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.thr (limit_threshold_q),
		.lim (lim_res)
	);

	// Echo history
	assign ring_waddr = (state_q == ST_CLEAR) ? clr_q : wp_q;
	assign ring_wdata = (state_q == ST_CLEAR) ? '0 : {rg_q, lg_q};

	sgme_ring #(
		.RING_DEPTH (RING_DEPTH),
		.SAMPLE_BITS(SB)
	) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(ring_waddr),
		.wdata(ring_wdata),
		.re   (ring_re),
		.raddr(rp),
		.rdata(ring_rdata)
	);

	// A zero distance reads back the sample being written
	assign echo_l = (dmod_a == '0) ? lg_q : ring_rdata[SB-1:0];
	assign echo_r = (dmod_a == '0) ? rg_q : ring_rdata[2*SB-1:SB];

	// Datapath registers, loaded as the sequencer passes
	always_ff @(posedge clk) begin
		if (in_take) begin
			in_l_q <= s_axis_tdata[SB-1:0];
			in_r_q <= s_axis_tdata[2*SB-1:SB];
		end
		if (state_q == ST_MUL_R) begin
			lg_q <= lim_res;
		end
		if (state_q == ST_LIM_R) begin
			rg_q <= lim_res;
		end
		if (state_q == ST_SUM) begin
			le_q <= sat_add(lg_q, echo_l);
			re_q <= sat_add(rg_q, echo_r);
		end
		if (state_q == ST_LEFT) begin
			center_q <= lim_res;
		end
		if (out_load) begin
			left_out_q   <= lim_res;
			right_out_q  <= re_q;
			center_out_q <= center_q;
		end
	end

	// Output request valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({center_out_q, right_out_q, left_out_q});

`ifndef SYNTHESIS
	// One pair at a time: no new request right after one is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> !s_axis_tready)
		else $error("input taken while a pair is in progress");

	// A result is never loaded over one that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_axis_tready))
		else $error("result overwritten before delivery");

	// Each delivered pair moves the write position
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (wp_q != $past(wp_q)))
		else $error("write position did not advance");

	// Input is refused and the ring is not read throughout the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!s_axis_tready && !ring_re))
		else $error("ring accessed for a pair while clearing");
`endif

endmodule

[tb/stereo_gain_mix_echo_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_gain_mix_echo_tb - self-checking bench for the stereo gain/mix/echo
// Drives stereo pairs over the input stream and predicts every left, right
// and centre result in a scoreboard with its own gain, limiter and echo rings.
// Register settings change between phases while the block is idle; both
// stream sides idle at random, apart from one phase that runs at full rate.
// ----------------------------------------------------------------------------
module stereo_gain_mix_echo_tb;
	import sgme_pkg::*;

	localparam int SW          = 24;
	localparam int DEPTH       = 16;
	localparam int QUIET_LIMIT = 2000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_PAIRS = 128;
	localparam logic [SW-1:0] S_MAX  = 24'h7FFFFF;
	localparam logic [SW-1:0] S_MIN  = 24'h800000;
	localparam logic [SW-1:0] S_ZERO = 24'h000000;

	// One result, packed as it arrives on m_axis_tdata (left in the lowest bits)
	typedef struct packed {
		logic [SW-1:0] center;
		logic [SW-1:0] right;
		logic [SW-1:0] left;
	} mix_t;

	// Predicts each result from an accepted pair and checks arriving results
	class echo_mix_board;
		longint      in_gain, hr_gain, ad_gain, thresh;
		int unsigned delay, wr_pos;
		longint      left_ring[DEPTH];
		longint      right_ring[DEPTH];
		mix_t        pending[$];
		int unsigned fails;

		function new();
			in_gain = INPUT_GAIN_RST;
			hr_gain = HEADROOM_GAIN_RST;
			ad_gain = AFTER_DELAY_GAIN_RST;
			thresh  = LIMIT_THRESHOLD_RST;
			delay   = DELAY_AMOUNT_RST;
			wr_pos  = DEPTH - 1;
			fails   = 0;
			foreach (left_ring[i]) begin
				left_ring[i]  = 0;
				right_ring[i] = 0;
			end
		endfunction

		// Q1.23 product, floored
		function longint qmul(longint a, longint b);
			return (a * b) >>> (SW - 1);
		endfunction

		function longint clip(longint v);
			if (v > thresh)
				return thresh;
			if (v < -thresh)
				return -thresh;
			return v;
		endfunction

		function longint clamp(longint v);
			if (v > longint'($signed(S_MAX)))
				return longint'($signed(S_MAX));
			if (v < longint'($signed(S_MIN)))
				return longint'($signed(S_MIN));
			return v;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SW-1:0] val);
			case (idx)
				CFG_INPUT_GAIN:       in_gain = longint'($signed(val));
				CFG_HEADROOM_GAIN:    hr_gain = longint'($signed(val));
				CFG_AFTER_DELAY_GAIN: ad_gain = longint'($signed(val));
				CFG_LIMIT_THRESHOLD:  thresh  = longint'(val[SW-2:0]);
				CFG_DELAY_AMOUNT:     delay   = val[DELAY_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_pair(logic [SW-1:0] l, logic [SW-1:0] r);
			longint      lg, rg, ctr, le, re;
			int unsigned rp;
			mix_t        m;
			lg  = clip(qmul(longint'($signed(l)), in_gain));
			rg  = clip(qmul(longint'($signed(r)), in_gain));
			ctr = clip(qmul(clamp(lg + rg), hr_gain));
			rp  = (wr_pos + DEPTH - delay) % DEPTH;
			left_ring[wr_pos]  = lg;
			right_ring[wr_pos] = rg;
			le = clamp(lg + left_ring[rp]);
			re = clamp(rg + right_ring[rp]);
			wr_pos = (wr_pos + 1) % DEPTH;
			le = clip(qmul(le, ad_gain));
			m.left   = le[SW-1:0];
			m.right  = re[SW-1:0];
			m.center = ctr[SW-1:0];
			pending.push_back(m);
		endfunction

		function void check_mix(logic [3*SW-1:0] data);
			mix_t got, want;
			got = data;
			if (pending.size() == 0) begin
				fails++;
				$display("%0t: result %h arrived with no pair outstanding", $time, data);
				return;
			end
			want = pending.pop_front();
			if (got.left !== want.left) begin
				fails++;
				$display("%0t: left_out expected %h, got %h", $time, want.left, got.left);
			end
			if (got.right !== want.right) begin
				fails++;
				$display("%0t: right_out expected %h, got %h", $time, want.right, got.right);
			end
			if (got.center !== want.center) begin
				fails++;
				$display("%0t: center_out expected %h, got %h", $time, want.center,
					got.center);
			end
		endfunction
	endclass

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = CFG_INPUT_GAIN;
	logic [SW-1:0]        cfg_data      = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [2*SW-1:0]      s_axis_tdata  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [3*SW-1:0]      m_axis_tdata;

	bit            tx_idles = 1'b1;
	bit            rx_idles = 1'b1;
	int unsigned   quiet_cycles = 0;
	echo_mix_board board = new();

	stereo_gain_mix_echo #(
		.RING_DEPTH (DEPTH),
		.SAMPLE_BITS(SW)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stall the result side at random
	always @(negedge clk) begin
		m_axis_tready <= !(rx_idles && $urandom_range(99) < 26);
	end

	// Check every result request taken
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			board.check_mix(m_axis_tdata);
	end

	// Abort when neither side moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("stereo_gain_mix_echo_tb NOT OK");
			$finish;
		end
	end

	// Offer one pair, with random gaps ahead of it, and hold until taken
	task automatic send_pair(input logic [SW-1:0] l, input logic [SW-1:0] r);
		@(negedge clk);
		while (tx_idles && $urandom_range(99) < 26) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {r, l};
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.take_pair(l, r);
	endtask

	// Drain the block, then write all registers and one unused index
	task automatic configure(input logic [SW-1:0] ig, input logic [SW-1:0] hg,
			input logic [SW-1:0] adg, input logic [SW-1:0] thr, input logic [SW-1:0] dly);
		logic [CFG_IDX_W-1:0] idx[6];
		logic [SW-1:0]        val[6];
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (12) @(negedge clk);
		idx = '{CFG_INPUT_GAIN, CFG_HEADROOM_GAIN, CFG_AFTER_DELAY_GAIN,
			CFG_LIMIT_THRESHOLD, CFG_DELAY_AMOUNT,
			CFG_IDX_W'(CFG_DELAY_AMOUNT + $urandom_range(1, 3))};
		val = '{ig, hg, adg, thr, dly, SW'($urandom)};
		foreach (idx[i]) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			board.set_reg(cfg_index, cfg_data);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Mostly full-range samples, with extremes and small magnitudes mixed in
	function automatic logic [SW-1:0] pick_sample();
		case ($urandom_range(9))
			0: return S_MAX;
			1: return S_MIN;
			2: return SW'($urandom_range(255)) ^ {SW{1'($urandom_range(1))}};
			default: return SW'($urandom);
		endcase
	endfunction

	function automatic logic [SW-1:0] pick_gain();
		case ($urandom_range(7))
			0: return S_MAX;
			1: return S_MIN;
			2: return SW'($urandom_range(24'h7FFFFF, 24'h600000));
			default: return SW'($urandom);
		endcase
	endfunction

	function automatic logic [SW-1:0] pick_threshold();
		case ($urandom_range(7))
			0: return S_ZERO;
			1: return S_MAX;
			2: return SW'($urandom_range(24'h0FFFFF));
			default: return SW'($urandom);
		endcase
	endfunction

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: field extremes
		send_pair(S_ZERO, S_ZERO);
		send_pair(S_MAX, S_MAX);
		send_pair(S_MIN, S_MIN);
		send_pair(S_MIN, S_MAX);
		send_pair(S_MAX, S_MIN);
		send_pair(24'h000001, 24'hFFFFFF);
		send_pair(24'h400000, 24'hC00000);

		// Gains of minus one, full threshold, echo of the sample just written
		configure(S_MIN, S_MIN, S_MIN, 24'hFFFFFF, 24'hFFFFF0);
		send_pair(S_MIN, S_MIN);
		send_pair(S_MAX, S_MAX);
		send_pair(S_MIN, S_MAX);
		send_pair(24'h000001, 24'hFFFFFF);

		// Zero threshold, longest echo
		configure(S_MAX, S_MAX, S_MAX, S_ZERO, 24'h00000F);
		send_pair(S_MAX, S_MAX);
		send_pair(S_MIN, S_MIN);
		send_pair(S_MAX, S_MIN);

		// Saturating echo sums at the shortest distance
		configure(S_MIN, S_MAX, S_MAX, S_MAX, 24'h000001);
		send_pair(S_MIN, S_MIN);
		send_pair(S_MIN, S_MIN);
		send_pair(S_MAX, S_MAX);
		send_pair(S_MAX, S_MAX);
		send_pair(S_MIN, S_MAX);

		// Random settings per phase; one phase without any idling
		for (int p = 0; p < RAND_PHASES; p++) begin
			configure(pick_gain(), pick_gain(), pick_gain(), pick_threshold(),
				SW'($urandom));
			tx_idles = (p != 3);
			rx_idles = (p != 3);
			for (int n = 0; n < PHASE_PAIRS; n++)
				send_pair(pick_sample(), pick_sample());
		end
		tx_idles = 1'b1;
		rx_idles = 1'b1;

		// Drain and let any stray result show up
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.fails == 0)
			$display("stereo_gain_mix_echo_tb OK");
		else
			$display("stereo_gain_mix_echo_tb NOT OK");
		$finish;
	end

endmodule
